FILE: hdl/esp_pkg.sv
// ----------------------------------------------------------------------------
// esp_pkg
// Shared widths, limits, register indexes and inter-stage types for the
// encoder speed and PID drive block.
// ----------------------------------------------------------------------------
`default_nettype none

package esp_pkg;

   // default build values
   localparam int SamplesPerUpdateDef = 20;
   localparam int EncoderBitsDef      = 14;

   // field and state widths
   localparam int SumW        = 19;
   localparam int SpeedFracW  = 8;
   localparam int SpeedW      = 23;
   localparam int ErrW        = 24;
   localparam int DeltaW      = 25;
   localparam int IntegW      = 48;
   localparam int IntegHalfW  = 24;
   localparam int DriveW      = 11;
   localparam int GainW       = 32;
   localparam int QShift      = 24;
   localparam int CsrIndexW   = 2;
   localparam int CsrDataW    = 32;
   localparam int RspDataW    = ((SpeedW + DriveW + 7) / 8) * 8;

   // integral product is held saturated at +-2^IpSatExp
   localparam int IpW         = 59;
   localparam int IpSatExp    = 57;

   localparam logic signed [SumW-1:0]   SumMax   = {1'b0, {(SumW-1){1'b1}}};
   localparam logic signed [SumW-1:0]   SumMin   = {1'b1, {(SumW-1){1'b0}}};
   localparam logic signed [SpeedW-1:0] SpeedMax = {1'b0, {(SpeedW-1){1'b1}}};
   localparam logic signed [SpeedW-1:0] SpeedMin = {1'b1, {(SpeedW-1){1'b0}}};
   localparam logic signed [IntegW-1:0] IntegMax = {1'b0, {(IntegW-1){1'b1}}};
   localparam logic signed [IntegW-1:0] IntegMin = {1'b1, {(IntegW-1){1'b0}}};

   localparam int ClearDriveMag = 500;
   localparam int ProdLimitMag  = 300;
   localparam int DriveLimitMag = 700;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_SET_SPEED = 2'd0,
      CSR_GAIN_P    = 2'd1,
      CSR_GAIN_I    = 2'd2,
      CSR_GAIN_D    = 2'd3
   } csr_index_type;

   // closed window: saturated sum of wrapped differences
   typedef struct packed {
      logic                   valid;
      logic signed [SumW-1:0] sum;
   } window_type;

   // mean speed and speed error of one window
   typedef struct packed {
      logic                     valid;
      logic signed [SpeedW-1:0] speed;
      logic signed [ErrW-1:0]   err;
   } speed_type;

   typedef struct packed {
      logic                     valid;
      logic signed [SpeedW-1:0] speed;
      logic signed [DriveW-1:0] drive;
   } result_type;

endpackage

`default_nettype wire

FILE: hdl/esp_velocity.sv
// ----------------------------------------------------------------------------
// esp_velocity
// Input register, wrapped angle difference, saturating window sum and
// sample counter. Hands a closed window to the speed divider.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_velocity
   import esp_pkg::*;
#(
   parameter int SAMPLES_PER_UPDATE = SamplesPerUpdateDef,
   parameter int ENCODER_BITS       = EncoderBitsDef
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [ENCODER_BITS-1:0] in_angle,
   input  logic                    hold_window,
   output window_type              window
);

   localparam int DiffW  = ENCODER_BITS + 2;
   localparam int CountW = $clog2(SAMPLES_PER_UPDATE + 1);
   localparam logic signed [DiffW-1:0] HalfTurn = DiffW'(64'd1 << (ENCODER_BITS - 1));
   localparam logic signed [DiffW-1:0] FullTurn = DiffW'(64'd1 << ENCODER_BITS);
   localparam logic [CountW-1:0] LastCount = CountW'(SAMPLES_PER_UPDATE - 1);

   logic                    in_valid_ff, in_valid_in;
   logic [ENCODER_BITS-1:0] angle_ff, angle_in;
   logic [ENCODER_BITS-1:0] prev_angle_ff, prev_angle_in;
   logic [CountW-1:0]       count_ff, count_in;
   logic signed [SumW-1:0]  sum_ff, sum_in;
   window_type              window_ff, window_in;

   logic                    last;
   logic                    go;
   logic signed [DiffW-1:0] diff_raw;
   logic signed [DiffW-1:0] diff_wrap;
   logic signed [SumW:0]    sum_wide;
   logic signed [SumW-1:0]  sum_sat;

   always_comb begin
      last     = (count_ff == LastCount);
      // a closing word waits until the PID path and result register are free
      go       = in_valid_ff && !(last && (hold_window || window_ff.valid));
      in_ready = !in_valid_ff || go;

      diff_raw = $signed({2'b00, angle_ff} - {2'b00, prev_angle_ff});
      if (diff_raw > HalfTurn) begin
         diff_wrap = diff_raw - FullTurn;
      end else if (diff_raw < -HalfTurn) begin
         diff_wrap = diff_raw + FullTurn;
      end else begin
         diff_wrap = diff_raw;
      end

      sum_wide = {sum_ff[SumW-1], sum_ff}
               + {{(SumW + 1 - DiffW){diff_wrap[DiffW-1]}}, diff_wrap};
      if (sum_wide[SumW] != sum_wide[SumW-1]) begin
         sum_sat = sum_wide[SumW] ? SumMin : SumMax;
      end else begin
         sum_sat = sum_wide[SumW-1:0];
      end

      in_valid_in   = in_valid_ff;
      angle_in      = angle_ff;
      prev_angle_in = prev_angle_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;

      if (in_valid && in_ready) begin
         in_valid_in = 1'b1;
         angle_in    = in_angle;
      end else if (go) begin
         in_valid_in = 1'b0;
      end

      if (go) begin
         prev_angle_in = angle_ff;
         if (last) begin
            count_in = '0;
            sum_in   = '0;
         end else begin
            count_in = CountW'(count_ff + 1'b1);
            sum_in   = sum_sat;
         end
      end

      window_in.valid = go && last;
      window_in.sum   = sum_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         prev_angle_ff   <= '0;
         count_ff        <= '0;
         sum_ff          <= '0;
         window_ff.valid <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         prev_angle_ff   <= prev_angle_in;
         count_ff        <= count_in;
         sum_ff          <= sum_in;
         window_ff.valid <= window_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      angle_ff      <= angle_in;
      window_ff.sum <= window_in.sum;
   end

   assign window = window_ff;

endmodule

`default_nettype wire

FILE: hdl/esp_speed_div.sv
// ----------------------------------------------------------------------------
// esp_speed_div
// Mean speed of a window: sum * 256 / SAMPLES_PER_UPDATE, truncated toward
// zero by a reciprocal multiply, saturated, then the speed error is formed.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_speed_div
   import esp_pkg::*;
#(
   parameter int SAMPLES_PER_UPDATE = SamplesPerUpdateDef
) (
   input  logic                     clock,
   input  logic                     reset,
   input  window_type               window,
   input  logic signed [SpeedW-1:0] set_speed,
   output speed_type                speed,
   output logic                     busy
);

   localparam int NumW  = SumW + SpeedFracW;
   localparam int Shift = NumW + $clog2(SAMPLES_PER_UPDATE);
   // ceil(2^Shift / N) is exact for every numerator below 2^NumW
   localparam longint unsigned Recip =
      ((64'd1 << Shift) + SAMPLES_PER_UPDATE - 1) / SAMPLES_PER_UPDATE;
   localparam int RecipW = $clog2(Recip + 1);
   localparam int ProdW  = Shift + NumW;
   localparam logic [RecipW-1:0] RecipK  = RecipW'(Recip);
   localparam logic [NumW-1:0]   PosMag  = NumW'(SpeedMax);
   localparam logic [NumW-1:0]   NegMag  = PosMag + NumW'(1);

   typedef struct packed {
      logic            valid;
      logic            neg;
      logic [NumW-1:0] quot;
   } quot_type;

   quot_type  quot_ff, quot_in;
   speed_type speed_ff, speed_in;

   logic [SumW-1:0]          mag;
   logic [NumW-1:0]          num;
   logic [ProdW-1:0]         prod;
   logic signed [SpeedW-1:0] speed_val;

   always_comb begin
      mag  = window.sum[SumW-1] ? SumW'(-window.sum) : SumW'(window.sum);
      num  = {mag, {SpeedFracW{1'b0}}};
      prod = ProdW'(num) * ProdW'(RecipK);

      quot_in.valid = window.valid;
      quot_in.neg   = window.sum[SumW-1];
      quot_in.quot  = prod[Shift +: NumW];

      if (quot_ff.neg) begin
         speed_val = (quot_ff.quot > NegMag) ? SpeedMin : -SpeedW'(quot_ff.quot);
      end else begin
         speed_val = (quot_ff.quot > PosMag) ? SpeedMax : SpeedW'(quot_ff.quot);
      end

      speed_in.valid = quot_ff.valid;
      speed_in.speed = speed_val;
      speed_in.err   = ErrW'(set_speed) - ErrW'(speed_val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff.valid  <= 1'b0;
         speed_ff.valid <= 1'b0;
      end else begin
         quot_ff.valid  <= quot_in.valid;
         speed_ff.valid <= speed_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff.neg    <= quot_in.neg;
      quot_ff.quot   <= quot_in.quot;
      speed_ff.speed <= speed_in.speed;
      speed_ff.err   <= speed_in.err;
   end

   assign speed = speed_ff;
   assign busy  = quot_ff.valid || speed_ff.valid;

endmodule

`default_nettype wire

FILE: hdl/esp_pid.sv
// ----------------------------------------------------------------------------
// esp_pid
// PID step on the speed error: products, integral product with its limit
// test, integrator update, clamp and truncation of the drive value.
// ----------------------------------------------------------------------------
`default_nettype none

module esp_pid
   import esp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  speed_type               speed,
   input  logic signed [GainW-1:0] gain_p,
   input  logic signed [GainW-1:0] gain_i,
   input  logic signed [GainW-1:0] gain_d,
   output result_type              result,
   output logic                    busy
);

   localparam int PW    = GainW + ErrW;
   localparam int DW    = GainW + DeltaW;
   localparam int PhW   = GainW + IntegHalfW;
   localparam int PlW   = GainW + IntegHalfW + 1;
   localparam int FullW = PhW + QShift;
   localparam int PdW   = DW + 1;
   localparam int TotW  = IpW + 1;

   localparam logic signed [FullW-1:0]  IpSatWide   = FullW'(64'd1 << IpSatExp);
   localparam logic signed [IpW-1:0]    IpSat       = IpW'(64'd1 << IpSatExp);
   localparam logic signed [IpW-1:0]    ProdLimit   = IpW'(64'(ProdLimitMag) << QShift);
   localparam logic signed [TotW-1:0]   DriveLimit  = TotW'(64'(DriveLimitMag) << QShift);
   localparam logic signed [DriveW-1:0] ClearDrive  = DriveW'(ClearDriveMag);

   typedef struct packed {
      logic                     valid;
      logic                     clear;
      logic signed [SpeedW-1:0] speed;
      logic signed [ErrW-1:0]   err;
      logic signed [PW-1:0]     pterm;
      logic signed [DW-1:0]     dterm;
      logic signed [PhW-1:0]    ph;
      logic signed [PlW-1:0]    pl;
      logic signed [PW-1:0]     gerr;
   } prod_type;

   typedef struct packed {
      logic                     valid;
      logic                     clear;
      logic signed [SpeedW-1:0] speed;
      logic signed [ErrW-1:0]   err;
      logic signed [IpW-1:0]    ip;
      logic signed [PdW-1:0]    pd;
      logic signed [PW-1:0]     gerr;
   } term_type;

   typedef struct packed {
      logic                     valid;
      logic signed [SpeedW-1:0] speed;
      logic signed [ErrW-1:0]   err;
      logic signed [IpW-1:0]    ip;
      logic signed [PdW-1:0]    pd;
   } sum_type;

   prod_type                 prod_ff, prod_in;
   term_type                 term_ff, term_in;
   sum_type                  sum_ff, sum_in;
   logic signed [ErrW-1:0]   prev_error_ff, prev_error_in;
   logic signed [IntegW-1:0] integral_ff, integral_in;
   logic signed [DriveW-1:0] prev_drive_ff, prev_drive_in;

   logic signed [DeltaW-1:0]     delta;
   logic signed [IntegHalfW-1:0] integ_hi;
   logic signed [IntegHalfW:0]   integ_lo;
   logic signed [FullW-1:0]      ip_full;
   logic                         accumulate;
   logic signed [IntegW:0]       integ_wide;
   logic signed [TotW-1:0]       total;
   logic signed [TotW-1:0]       clamped;
   logic [TotW-1:0]              total_mag;
   logic [DriveW-1:0]            drive_mag;
   logic signed [DriveW-1:0]     drive;

   // products on the fresh error and on the stored integral
   always_comb begin
      delta    = DeltaW'(speed.err) - DeltaW'(prev_error_ff);
      integ_hi = integral_ff[IntegW-1 -: IntegHalfW];
      integ_lo = $signed({1'b0, integral_ff[IntegHalfW-1:0]});

      prod_in.valid = speed.valid;
      prod_in.clear = (speed.err < 0 && prev_error_ff > 0)
                   || (speed.err > 0 && prev_error_ff < 0)
                   || prev_drive_ff > ClearDrive
                   || prev_drive_ff < -ClearDrive;
      prod_in.speed = speed.speed;
      prod_in.err   = speed.err;
      prod_in.pterm = PW'(gain_p) * PW'(speed.err);
      prod_in.dterm = DW'(gain_d) * DW'(delta);
      prod_in.ph    = PhW'(gain_i) * PhW'(integ_hi);
      prod_in.pl    = PlW'(gain_i) * PlW'(integ_lo);
      prod_in.gerr  = PW'(gain_i) * PW'(speed.err);
   end

   // join the integral partial products and saturate them
   always_comb begin
      ip_full = (FullW'(prod_ff.ph) <<< QShift) + FullW'(prod_ff.pl);

      term_in.valid = prod_ff.valid;
      term_in.clear = prod_ff.clear;
      term_in.speed = prod_ff.speed;
      term_in.err   = prod_ff.err;
      if (ip_full > IpSatWide) begin
         term_in.ip = IpSat;
      end else if (ip_full < -IpSatWide) begin
         term_in.ip = -IpSat;
      end else begin
         term_in.ip = IpW'(ip_full);
      end
      term_in.pd   = PdW'(prod_ff.pterm) + PdW'(prod_ff.dterm);
      term_in.gerr = prod_ff.gerr;
   end

   // integrator update; the new integral product follows without a multiply
   always_comb begin
      accumulate = !term_ff.clear && term_ff.ip > -ProdLimit && term_ff.ip < ProdLimit;
      integ_wide = (IntegW + 1)'(integral_ff) + (IntegW + 1)'(term_ff.err);

      integral_in = integral_ff;
      sum_in.valid = term_ff.valid;
      sum_in.speed = term_ff.speed;
      sum_in.err   = term_ff.err;
      sum_in.pd    = term_ff.pd;
      if (term_ff.clear) begin
         sum_in.ip = '0;
      end else if (accumulate) begin
         sum_in.ip = term_ff.ip + IpW'(term_ff.gerr);
      end else begin
         sum_in.ip = term_ff.ip;
      end

      if (term_ff.valid) begin
         if (term_ff.clear) begin
            integral_in = '0;
         end else if (accumulate) begin
            if (integ_wide[IntegW] != integ_wide[IntegW-1]) begin
               integral_in = integ_wide[IntegW] ? IntegMin : IntegMax;
            end else begin
               integral_in = integ_wide[IntegW-1:0];
            end
         end
      end
   end

   // total, clamp and truncate toward zero
   always_comb begin
      total = TotW'(sum_ff.pd) + TotW'(sum_ff.ip);
      if (total > DriveLimit) begin
         clamped = DriveLimit;
      end else if (total < -DriveLimit) begin
         clamped = -DriveLimit;
      end else begin
         clamped = total;
      end
      total_mag = clamped[TotW-1] ? TotW'(-clamped) : TotW'(clamped);
      drive_mag = total_mag[QShift +: DriveW];
      drive     = clamped[TotW-1] ? -$signed(drive_mag) : $signed(drive_mag);

      prev_error_in = prev_error_ff;
      prev_drive_in = prev_drive_ff;
      if (sum_ff.valid) begin
         prev_error_in = sum_ff.err;
         prev_drive_in = drive;
      end

      result.valid = sum_ff.valid;
      result.speed = sum_ff.speed;
      result.drive = drive;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff.valid <= 1'b0;
         term_ff.valid <= 1'b0;
         sum_ff.valid  <= 1'b0;
         prev_error_ff <= '0;
         integral_ff   <= '0;
         prev_drive_ff <= '0;
      end else begin
         prod_ff.valid <= prod_in.valid;
         term_ff.valid <= term_in.valid;
         sum_ff.valid  <= sum_in.valid;
         prev_error_ff <= prev_error_in;
         integral_ff   <= integral_in;
         prev_drive_ff <= prev_drive_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff.clear <= prod_in.clear;
      prod_ff.speed <= prod_in.speed;
      prod_ff.err   <= prod_in.err;
      prod_ff.pterm <= prod_in.pterm;
      prod_ff.dterm <= prod_in.dterm;
      prod_ff.ph    <= prod_in.ph;
      prod_ff.pl    <= prod_in.pl;
      prod_ff.gerr  <= prod_in.gerr;
      term_ff.clear <= term_in.clear;
      term_ff.speed <= term_in.speed;
      term_ff.err   <= term_in.err;
      term_ff.ip    <= term_in.ip;
      term_ff.pd    <= term_in.pd;
      term_ff.gerr  <= term_in.gerr;
      sum_ff.speed  <= sum_in.speed;
      sum_ff.err    <= sum_in.err;
      sum_ff.ip     <= sum_in.ip;
      sum_ff.pd     <= sum_in.pd;
   end

   assign busy = prod_ff.valid || term_ff.valid || sum_ff.valid;

endmodule

`default_nettype wire

FILE: hdl/encoder_speed_pid_core.sv
// ----------------------------------------------------------------------------
// encoder_speed_pid_core
// Encoder speed measurement over a window of samples with a PID drive step.
// ----------------------------------------------------------------------------
// Path: the sample that closes a window passes the input, window, quotient,
// speed, product, term, sum and result registers before its word is offered.
// Throughput: one sample per cycle. The closing sample of a window waits while
// the previous PID step (6 stages) is in flight or its result word is untaken,
// so full rate holds for SAMPLES_PER_UPDATE >= 8 with a prompt consumer.
// Reset: synchronous; clears angle history, window, integrator, gains, target.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_speed_pid_core
   import esp_pkg::*;
#(
   parameter int SAMPLES_PER_UPDATE = SamplesPerUpdateDef,
   parameter int ENCODER_BITS       = EncoderBitsDef
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // [ENCODER_BITS-1:0] encoder_angle, rest unused
   input  logic [((ENCODER_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // [22:0] measured_speed, [33:23] drive_value, [39:34] zero
   output logic [RspDataW-1:0]                      rsp_tdata,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [CsrIndexW-1:0]                     csr_index,
   input  logic [CsrDataW-1:0]                      csr_data
);

   logic signed [SpeedW-1:0] target_ff, target_in;
   logic signed [GainW-1:0]  gain_p_ff, gain_p_in;
   logic signed [GainW-1:0]  gain_i_ff, gain_i_in;
   logic signed [GainW-1:0]  gain_d_ff, gain_d_in;
   result_type               rsp_ff, rsp_in;

   window_type window;
   speed_type  speed;
   result_type result;
   logic       div_busy;
   logic       pid_busy;
   logic       hold_window;

   assign csr_ready = 1'b1;

   always_comb begin
      target_in = target_ff;
      gain_p_in = gain_p_ff;
      gain_i_in = gain_i_ff;
      gain_d_in = gain_d_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_SET_SPEED: target_in = csr_data[SpeedW-1:0];
            CSR_GAIN_P:    gain_p_in = csr_data[GainW-1:0];
            CSR_GAIN_I:    gain_i_in = csr_data[GainW-1:0];
            CSR_GAIN_D:    gain_d_in = csr_data[GainW-1:0];
         endcase
      end
   end

   // the result register is always empty when a PID step completes
   always_comb begin
      rsp_in = rsp_ff;
      if (result.valid) begin
         rsp_in = result;
      end else if (rsp_tready) begin
         rsp_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         rsp_ff.valid <= 1'b0;
      end else begin
         target_ff    <= target_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         rsp_ff.valid <= rsp_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.speed <= rsp_in.speed;
      rsp_ff.drive <= rsp_in.drive;
   end

   assign hold_window = div_busy || pid_busy || rsp_ff.valid;

   esp_velocity #(
      .SAMPLES_PER_UPDATE (SAMPLES_PER_UPDATE),
      .ENCODER_BITS       (ENCODER_BITS)
   ) u_velocity (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_angle    (req_tdata[ENCODER_BITS-1:0]),
      .hold_window (hold_window),
      .window      (window)
   );

   esp_speed_div #(
      .SAMPLES_PER_UPDATE (SAMPLES_PER_UPDATE)
   ) u_speed_div (
      .clock     (clock),
      .reset     (reset),
      .window    (window),
      .set_speed (target_ff),
      .speed     (speed),
      .busy      (div_busy)
   );

   esp_pid u_pid (
      .clock  (clock),
      .reset  (reset),
      .speed  (speed),
      .gain_p (gain_p_ff),
      .gain_i (gain_i_ff),
      .gain_d (gain_d_ff),
      .result (result),
      .busy   (pid_busy)
   );

   assign rsp_tvalid = rsp_ff.valid;
   assign rsp_tdata  = {{(RspDataW - SpeedW - DriveW){1'b0}}, rsp_ff.drive, rsp_ff.speed};

endmodule

`default_nettype wire
